FILE: hw/rtl/bms_pkg.sv
// shared constants, types and helper functions for the burst memory slave
`default_nettype none
package bms_pkg;

  localparam int QUEUE_DEPTH    = 16;
  localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_ADDR_BITS  = 16;
  localparam int MEM_WORDS      = 1 << MEM_ADDR_BITS;
  localparam int BYTES_PER_BEAT = 8;
  localparam int ADDR_W         = 32;
  localparam int DATA_W         = 64;
  localparam int LEN_W          = 8;
  localparam int TAG_W          = 8;

  typedef logic [QPTR_W-1:0]        qptr_t;
  typedef logic [QCNT_W-1:0]        qcnt_t;
  typedef logic [MEM_ADDR_BITS-1:0] widx_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  left;
    logic [TAG_W-1:0]  tag;
  } burst_entry_t;

  // controller to datapath
  typedef struct packed {
    logic accept;     // take the request on the input ports
    logic rd_issue;   // read memory at the head burst address
    logic resp_load;  // build the result and update the head burst
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_full;   // output register holds a result not yet taken
  } dp_status_t;

  function automatic widx_t word_index(input logic [ADDR_W-1:0] byte_addr);
    word_index = byte_addr[MEM_ADDR_BITS+2:3];
  endfunction

  function automatic qptr_t next_slot(input qptr_t ptr);
    if (ptr == qptr_t'(QUEUE_DEPTH - 1)) begin
      next_slot = '0;
    end else begin
      next_slot = ptr + qptr_t'(1);
    end
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/bms_ctrl.sv
// controller state machine: request accept, memory read, result build
`default_nettype none
module bms_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   out_ready,
  input  wire bms_pkg::dp_status_t    status,
  output bms_pkg::ctrl_cmd_t          cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready      = (state_r == ST_IDLE);
  assign cmd.accept    = in_valid && in_ready;
  assign cmd.rd_issue  = (state_r == ST_READ);
  assign cmd.resp_load = (state_r == ST_RESP) && (!status.out_full || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (cmd.resp_load) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/bms_datapath.sv
// datapath: burst queue, write pointer, word memory and output register
`default_nettype none
module bms_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bms_pkg::ctrl_cmd_t            cmd,
  output bms_pkg::dp_status_t                status,
  input  wire logic                          in_read_request,
  input  wire logic [bms_pkg::LEN_W-1:0]     in_read_length,
  input  wire logic [bms_pkg::TAG_W-1:0]     in_read_tag,
  input  wire logic [bms_pkg::ADDR_W-1:0]    in_read_address,
  input  wire logic                          in_write_request,
  input  wire logic [bms_pkg::ADDR_W-1:0]    in_write_address,
  input  wire logic                          in_write_beat,
  input  wire logic [bms_pkg::DATA_W-1:0]    in_write_data,
  input  wire logic                          in_reader_ready,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               out_beat_valid,
  output logic [bms_pkg::TAG_W-1:0]          out_beat_tag,
  output logic [bms_pkg::DATA_W-1:0]         out_beat_data,
  output logic                               out_request_dropped
);

  bms_pkg::burst_entry_t queue_r [bms_pkg::QUEUE_DEPTH];
  bms_pkg::qptr_t        head_r;
  bms_pkg::qptr_t        tail_r;
  bms_pkg::qcnt_t        count_r;
  logic [bms_pkg::ADDR_W-1:0] wp_r;
  logic [bms_pkg::ADDR_W-1:0] wp_eff;

  logic [bms_pkg::DATA_W-1:0] mem [bms_pkg::MEM_WORDS];
  logic [bms_pkg::DATA_W-1:0] rdata_r;

  logic ready_r;
  logic drop_r;
  logic queue_full;
  logic queue_busy;
  bms_pkg::burst_entry_t head_entry;

  logic                        out_valid_r;
  logic                        beat_valid_r;
  logic [bms_pkg::TAG_W-1:0]   beat_tag_r;
  logic [bms_pkg::DATA_W-1:0]  beat_data_r;
  logic                        dropped_r;

  assign queue_full = (count_r == bms_pkg::qcnt_t'(bms_pkg::QUEUE_DEPTH));
  assign queue_busy = (count_r != '0);
  assign head_entry = queue_r[head_r];
  assign wp_eff     = in_write_request ? in_write_address : wp_r;

  // queue pointers, count and write pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      wp_r    <= '0;
    end else if (cmd.accept) begin
      if (in_read_request && !queue_full) begin
        tail_r  <= bms_pkg::next_slot(tail_r);
        count_r <= count_r + bms_pkg::qcnt_t'(1);
      end
      wp_r <= in_write_beat ? wp_eff + bms_pkg::ADDR_W'(bms_pkg::BYTES_PER_BEAT) : wp_eff;
    end else if (cmd.resp_load && queue_busy && ready_r && (head_entry.left == '0)) begin
      head_r  <= bms_pkg::next_slot(head_r);
      count_r <= count_r - bms_pkg::qcnt_t'(1);
    end
  end

  // queue entries: enqueue at tail, step the head burst
  always_ff @(posedge clk) begin
    if (cmd.accept && in_read_request && !queue_full) begin
      queue_r[tail_r] <= '{addr: in_read_address, left: in_read_length, tag: in_read_tag};
    end else if (cmd.resp_load && queue_busy && ready_r) begin
      queue_r[head_r].addr <= head_entry.addr + bms_pkg::ADDR_W'(bms_pkg::BYTES_PER_BEAT);
      if (head_entry.left != '0) begin
        queue_r[head_r].left <= head_entry.left - bms_pkg::LEN_W'(1);
      end
    end
  end

  // per-request flags
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ready_r <= in_reader_ready;
      drop_r  <= in_read_request && queue_full;
    end
  end

  // word memory: write port
  always_ff @(posedge clk) begin
    if (cmd.accept && in_write_beat) begin
      mem[bms_pkg::word_index(wp_eff)] <= in_write_data;
    end
  end

  // word memory: registered read port
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rdata_r <= mem[bms_pkg::word_index(head_entry.addr)];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resp_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      beat_valid_r <= queue_busy;
      beat_tag_r   <= queue_busy ? head_entry.tag : '0;
      beat_data_r  <= queue_busy ? rdata_r : '0;
      dropped_r    <= drop_r;
    end
  end

  assign status.out_full     = out_valid_r;
  assign out_valid           = out_valid_r;
  assign out_beat_valid      = beat_valid_r;
  assign out_beat_tag        = beat_tag_r;
  assign out_beat_data       = beat_data_r;
  assign out_request_dropped = dropped_r;

endmodule
`default_nettype wire

FILE: hw/rtl/burst_memory_slave.sv
// top level of the beat-level burst memory slave
// usage:
//   each request on the in_ channel is one bus cycle of a memory slave: an
//   optional read burst request (address, length, tag), an optional write
//   burst start address, an optional 64-bit write beat and the reader's ready
//   the out_ channel returns one result per request: the beat presented by
//   the head read burst (valid, tag, data) and a flag for a read request that
//   met a full burst queue
//   sequencing: a request goes through accept, memory read and result build;
//   a new request is taken only after the last one has built its result, which
//   may wait on a stalled receiver. the read step is there for the registered
//   read port of the word memory, read after the write of the same request has landed
//   a write beat is visible to the read of the same request
//   reset (rst_n low, synchronous) empties the queue, zeroes the write pointer
//   and drops any pending result; memory contents stay undefined until written
//   when the receiver stalls the result waits in the output register; the next
//   request is still accepted and is processed up to its memory read, then
//   waits for the output register to free
`default_nettype none
module burst_memory_slave (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_read_request,
  input  wire logic [bms_pkg::LEN_W-1:0]     in_read_length,
  input  wire logic [bms_pkg::TAG_W-1:0]     in_read_tag,
  input  wire logic [bms_pkg::ADDR_W-1:0]    in_read_address,
  input  wire logic                          in_write_request,
  input  wire logic [bms_pkg::ADDR_W-1:0]    in_write_address,
  input  wire logic                          in_write_beat,
  input  wire logic [bms_pkg::DATA_W-1:0]    in_write_data,
  input  wire logic                          in_reader_ready,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_beat_valid,
  output logic [bms_pkg::TAG_W-1:0]          out_beat_tag,
  output logic [bms_pkg::DATA_W-1:0]         out_beat_data,
  output logic                               out_request_dropped
);

  // command and status between controller and datapath
  bms_pkg::ctrl_cmd_t  cmd;
  bms_pkg::dp_status_t status;

  // sequencing: idle, memory read, result build
  bms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // burst queue, write pointer, word memory and output register
  bms_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_read_request     (in_read_request),
    .in_read_length      (in_read_length),
    .in_read_tag         (in_read_tag),
    .in_read_address     (in_read_address),
    .in_write_request    (in_write_request),
    .in_write_address    (in_write_address),
    .in_write_beat       (in_write_beat),
    .in_write_data       (in_write_data),
    .in_reader_ready     (in_reader_ready),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_beat_valid      (out_beat_valid),
    .out_beat_tag        (out_beat_tag),
    .out_beat_data       (out_beat_data),
    .out_request_dropped (out_request_dropped)
  );

  // an accepted request takes the block out of idle, so in_ready drops
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted in consecutive cycles");

  // an empty presented beat carries zero tag and data
  a_empty_beat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_beat_valid |-> (out_beat_tag == '0) && (out_beat_data == '0))
    else $error("empty beat with nonzero tag or data");

  // a dropped request means the queue was full, so a beat is presented
  a_drop_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_request_dropped |-> out_beat_valid)
    else $error("request dropped while no beat presented");

endmodule
`default_nettype wire

FILE: sim/burst_memory_slave_test.sv
// self-checking testbench for the burst memory slave: directed table, preload and random requests
module burst_memory_slave_test;
  timeunit 1ns;
  timeprecision 1ps;

  // sizes and types shared with the design
  localparam int LEN_W          = bms_pkg::LEN_W;
  localparam int TAG_W          = bms_pkg::TAG_W;
  localparam int ADDR_W         = bms_pkg::ADDR_W;
  localparam int DATA_W         = bms_pkg::DATA_W;
  localparam int QUEUE_DEPTH    = bms_pkg::QUEUE_DEPTH;
  localparam int MEM_WORDS      = bms_pkg::MEM_WORDS;
  localparam int BYTES_PER_BEAT = bms_pkg::BYTES_PER_BEAT;

  typedef bms_pkg::qptr_t        qptr_t;
  typedef bms_pkg::qcnt_t        qcnt_t;
  typedef bms_pkg::widx_t        widx_t;
  typedef bms_pkg::burst_entry_t burst_entry_t;

  // one bus cycle of the slave as carried by a single request
  typedef struct packed {
    logic              rd_req;
    logic [LEN_W-1:0]  rd_len;
    logic [TAG_W-1:0]  rd_tag;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_req;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_beat;
    logic [DATA_W-1:0] wr_data;
    logic              rdy;
  } bus_cycle_t;

  // what the slave answers for that cycle
  typedef struct packed {
    logic              beat_valid;
    logic [TAG_W-1:0]  beat_tag;
    logic [DATA_W-1:0] beat_data;
    logic              dropped;
  } beat_t;

  // a hand-written answer, used only where it is plain from the behaviour
  typedef struct packed {
    bit    typed;
    beat_t want;
  } known_beat_t;

  typedef struct {
    bus_cycle_t  c;
    known_beat_t k;
  } table_row_t;

  // preload covers the top of the word space and wraps round to the bottom
  localparam widx_t       PRELOAD_BASE     = 16'hFFC0;
  localparam int unsigned PRELOAD_WORDS    = 384;
  localparam int          RANDOM_PER_PHASE = 375;
  localparam int          HOLD_CYCLES      = 400;
  localparam int          STUCK_LIMIT      = 4000;
  localparam int          DRAIN_CYCLES     = 12;
  localparam int          RECENT_KEEP      = 64;
  localparam int          IDLE_BY_PHASE  [4] = '{0, 76, 0, 29};
  localparam int          STALL_BY_PHASE [4] = '{0, 0, 76, 29};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid         = 1'b0;
  logic              in_ready;
  logic              in_read_request  = 1'b0;
  logic [LEN_W-1:0]  in_read_length   = '0;
  logic [TAG_W-1:0]  in_read_tag      = '0;
  logic [ADDR_W-1:0] in_read_address  = '0;
  logic              in_write_request = 1'b0;
  logic [ADDR_W-1:0] in_write_address = '0;
  logic              in_write_beat    = 1'b0;
  logic [DATA_W-1:0] in_write_data    = '0;
  logic              in_reader_ready  = 1'b0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_beat_valid;
  logic [TAG_W-1:0]  out_beat_tag;
  logic [DATA_W-1:0] out_beat_data;
  logic              out_request_dropped;

  burst_memory_slave i_dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow of the slave: burst queue, write pointer and word memory
  // ---------------------------------------------------------------------------
  burst_entry_t      bursts [QUEUE_DEPTH];
  qptr_t             q_head  = '0;
  qptr_t             q_tail  = '0;
  qcnt_t             q_count = '0;
  logic [ADDR_W-1:0] wr_ptr  = '0;
  logic [DATA_W-1:0] mem_shadow [MEM_WORDS];

  // one cycle of the slave: queue the read, move the write pointer, store the
  // write beat, then present the head burst (so a same-cycle write is seen)
  function automatic beat_t slave_cycle(input bus_cycle_t c);
    beat_t r;
    r = '0;
    if (c.rd_req) begin
      // fullness is taken before the head can retire this cycle
      if (q_count == qcnt_t'(QUEUE_DEPTH)) begin
        r.dropped = 1'b1;
      end else begin
        bursts[q_tail] = {c.rd_addr, c.rd_len, c.rd_tag};
        q_tail  = (q_tail == qptr_t'(QUEUE_DEPTH - 1)) ? '0 : q_tail + 1'b1;
        q_count = q_count + 1'b1;
      end
    end
    if (c.wr_req) begin
      wr_ptr = c.wr_addr;
    end
    if (c.wr_beat) begin
      mem_shadow[widx_t'(wr_ptr >> 3)] = c.wr_data;
      wr_ptr = wr_ptr + ADDR_W'(BYTES_PER_BEAT);
    end
    if (q_count != '0) begin
      r.beat_valid = 1'b1;
      r.beat_tag   = bursts[q_head].tag;
      r.beat_data  = mem_shadow[widx_t'(bursts[q_head].addr >> 3)];
      if (c.rdy) begin
        bursts[q_head].addr = bursts[q_head].addr + ADDR_W'(BYTES_PER_BEAT);
        if (bursts[q_head].left == '0) begin
          q_head  = (q_head == qptr_t'(QUEUE_DEPTH - 1)) ? '0 : q_head + 1'b1;
          q_count = q_count - 1'b1;
        end else begin
          bursts[q_head].left = bursts[q_head].left - 1'b1;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus side bookkeeping: which words have been written so far, so that
  // no read burst ever touches a word that was never written
  // ---------------------------------------------------------------------------
  bit                written_map [MEM_WORDS];
  widx_t             recent_words [$];
  logic [ADDR_W-1:0] gen_wptr = '0;
  known_beat_t       known_q [$];
  beat_t             beats_due [$];
  table_row_t        directed_rows [$];

  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;

  int requests_sent  = 0;
  int requests_seen  = 0;
  int results_seen   = 0;
  int beats_shown    = 0;
  int drops_seen     = 0;
  int longest_burst  = 0;
  int failures       = 0;

  function automatic bus_cycle_t cyc(input logic rq, input logic [LEN_W-1:0] len,
                                     input logic [TAG_W-1:0] tag, input logic [ADDR_W-1:0] ra,
                                     input logic wq, input logic [ADDR_W-1:0] wa,
                                     input logic wb, input logic [DATA_W-1:0] wd,
                                     input logic rdy);
    return {rq, len, tag, ra, wq, wa, wb, wd, rdy};
  endfunction

  function automatic beat_t beat(input logic v, input logic [TAG_W-1:0] t,
                                 input logic [DATA_W-1:0] d, input logic drop);
    return {v, t, d, drop};
  endfunction

  // append one row to the directed table
  function automatic void add_row(input bus_cycle_t c, input known_beat_t k);
    table_row_t row;
    row.c = c;
    row.k = k;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // number of written words in a row from w, capped at the longest burst
  function automatic int unsigned written_run(input widx_t w);
    int unsigned n;
    n = 0;
    while (n < 256 && written_map[widx_t'(w + n)]) n++;
    return n;
  endfunction

  // random cycle; a read burst only ever covers words already written
  function automatic bus_cycle_t random_request(input int rdy_pct);
    bus_cycle_t  c;
    int unsigned len;
    int unsigned run;
    int          pick;
    widx_t       w;
    c.rd_req  = ($urandom_range(99) < 35);
    c.rd_len  = LEN_W'($urandom);
    c.rd_tag  = TAG_W'($urandom);
    c.rd_addr = $urandom;
    c.wr_req  = ($urandom_range(99) < 10);
    c.wr_addr = $urandom;
    c.wr_beat = 1'($urandom_range(1));
    c.wr_data = {$urandom, $urandom};
    c.rdy     = ($urandom_range(99) < rdy_pct);
    if (c.rd_req) begin
      // mostly short bursts, now and then up to the full 256 beats
      pick = $urandom_range(99);
      if (pick < 60) begin
        len = $urandom_range(3);
      end else if (pick < 90) begin
        len = $urandom_range(15);
      end else begin
        len = $urandom_range(255);
      end
      if (recent_words.size() != 0 && $urandom_range(3) == 0) begin
        // read back something written lately, as far as the written run goes
        w   = recent_words[$urandom_range(recent_words.size() - 1)];
        run = written_run(w);
        if (len > run - 1) len = run - 1;
      end else begin
        w = widx_t'(PRELOAD_BASE + $urandom_range(PRELOAD_WORDS - 1 - len));
      end
      c.rd_len  = LEN_W'(len);
      // upper and low address bits are don't-care for the word index
      c.rd_addr = ($urandom & 32'hFFF8_0007) | (ADDR_W'(w) << 3);
    end
    return c;
  endfunction

  // offer one request, with random idle cycles ahead of it, and wait for it
  // to be taken
  task automatic send_request(input bus_cycle_t c, input bit typed, input beat_t want);
    widx_t       w;
    known_beat_t kb;
    if (c.wr_req) gen_wptr = c.wr_addr;
    if (c.wr_beat) begin
      w = widx_t'(gen_wptr >> 3);
      written_map[w] = 1'b1;
      recent_words.insert(recent_words.size(), w);
      if (recent_words.size() > RECENT_KEEP) recent_words.delete(0);
      gen_wptr = gen_wptr + ADDR_W'(BYTES_PER_BEAT);
    end
    if (c.rd_req && int'(c.rd_len) + 1 > longest_burst) longest_burst = int'(c.rd_len) + 1;
    kb.typed = typed;
    kb.want  = want;
    known_q.insert(known_q.size(), kb);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    {in_read_request, in_read_length, in_read_tag, in_read_address, in_write_request,
     in_write_address, in_write_beat, in_write_data, in_reader_ready} <= c;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: predict on every accepted request, compare on every result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    bus_cycle_t  seen;
    known_beat_t k;
    beat_t       pred;
    beat_t       got;
    beat_t       want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        seen = {in_read_request, in_read_length, in_read_tag, in_read_address,
                in_write_request, in_write_address, in_write_beat, in_write_data,
                in_reader_ready};
        k    = known_q[0];
        known_q.delete(0);
        pred = slave_cycle(seen);
        beats_due.insert(beats_due.size(), k.typed ? k.want : pred);
        requests_seen++;
      end
      if (out_valid && out_ready) begin
        got = {out_beat_valid, out_beat_tag, out_beat_data, out_request_dropped};
        results_seen++;
        if (got.beat_valid) beats_shown++;
        if (got.dropped) drops_seen++;
        if (beats_due.size() == 0) begin
          failures++;
          $display("%0t ns: result with nothing expected, actual %h", $time, got);
        end else begin
          want = beats_due[0];
          beats_due.delete(0);
          check_field("beat_valid", DATA_W'(want.beat_valid), DATA_W'(got.beat_valid));
          check_field("beat_tag", DATA_W'(want.beat_tag), DATA_W'(got.beat_tag));
          check_field("beat_data", want.beat_data, got.beat_data);
          check_field("request_dropped", DATA_W'(want.dropped), DATA_W'(got.dropped));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off so the slave backs up and
  // drops in_ready while requests keep being offered
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog: too long with neither side moving means the slave has hung
  initial begin : watchdog
    int stuck;
    stuck = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
      if (stuck >= STUCK_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
                 $time, STUCK_LIMIT, requests_seen - results_seen);
        $display("[burst_memory_slave] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    bus_cycle_t c;
    int         rdy_pct;

    // directed table; answers typed in where they are obvious
    // idle after reset, all ignored fields at ones: nothing presented
    add_row(cyc(0, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0,
                64'hFFFF_FFFF_FFFF_FFFF, 1), '{1, beat(0, 0, 0, 0)});
    // write burst at the very top of the address space, pointer wraps to zero
    add_row(cyc(0, 0, 0, 0, 1, 32'hFFFF_FFF8, 1,
                64'hFFFF_FFFF_FFFF_FFFF, 0), '{1, beat(0, 0, 0, 0)});
    add_row(cyc(0, 0, 0, 0, 0, 0, 1, 64'h0, 0), '{1, beat(0, 0, 0, 0)});
    add_row(cyc(0, 0, 0, 0, 0, 0, 1, 64'h0123_4567_89AB_CDEF, 0),
            '{1, beat(0, 0, 0, 0)});
    // unaligned read at the top address, three beats wrapping past zero
    add_row(cyc(1, 8'd2, 8'hFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 1),
            '{1, beat(1, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 0)});
    add_row(cyc(0, 0, 0, 0, 0, 0, 0, 0, 1), '{1, beat(1, 8'hFF, 0, 0)});
    // reader not ready: same beat held
    add_row(cyc(0, 0, 0, 0, 0, 0, 0, 0, 0),
            '{1, beat(1, 8'hFF, 64'h0123_4567_89AB_CDEF, 0)});
    add_row(cyc(0, 0, 0, 0, 0, 0, 0, 0, 1),
            '{1, beat(1, 8'hFF, 64'h0123_4567_89AB_CDEF, 0)});
    // queue empty again
    add_row(cyc(0, 0, 0, 0, 0, 0, 0, 0, 1), '{1, beat(0, 0, 0, 0)});
    // write and read of the same word in one cycle, high address bits ignored
    add_row(cyc(1, 8'd0, 8'h5A, 32'h0000_0010, 1, 32'h7FF8_0011, 1,
                64'hFEDC_BA98_7654_3210, 1),
            '{1, beat(1, 8'h5A, 64'hFEDC_BA98_7654_3210, 0)});
    // fill the burst queue with the reader stalled
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      add_row(cyc(1, 8'd0, TAG_W'(i), ADDR_W'(i) << 28, 0, 0, 0, 0, 0),
              '{0, beat(0, 0, 0, 0)});
    end
    // full queue: request dropped even though the head retires this cycle
    add_row(cyc(1, 8'd7, 8'hEE, 32'h0000_0000, 0, 0, 0, 0, 1),
            '{1, beat(1, 8'h00, 64'h0, 1)});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].c, directed_rows[i].k.typed, directed_rows[i].k.want);
    end

    // preload one long write burst so that reads of up to 256 beats have data,
    // while the leftover queue drains
    idle_pct  = 29;
    stall_pct = 29;
    for (int k = 0; k < PRELOAD_WORDS; k++) begin
      c         = random_request(50);
      c.rd_req  = 1'b0;
      c.wr_req  = (k == 0);
      c.wr_addr = ($urandom & 32'hFFF8_0007) | (ADDR_W'(PRELOAD_BASE) << 3);
      c.wr_beat = 1'b1;
      send_request(c, 1'b0, '0);
    end

    // random phases with different idling on each side
    rdy_pct = 50;
    for (int p = 0; p < 4; p++) begin
      idle_pct  = IDLE_BY_PHASE[p];
      stall_pct = STALL_BY_PHASE[p];
      if (p == 0) hold_request = 1'b1;
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        // reader readiness changes in blocks so the queue both fills and drains
        if (k % 50 == 0) begin
          case ($urandom_range(2))
            0:       rdy_pct = 10;
            1:       rdy_pct = 50;
            default: rdy_pct = 95;
          endcase
        end
        send_request(random_request(rdy_pct), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (results_seen < requests_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d directed, %0d preload) and %0d results",
             requests_sent, directed_rows.size(), PRELOAD_WORDS, results_seen);
    $display("read beats presented %0d, requests dropped on a full queue %0d, longest burst %0d",
             beats_shown, drops_seen, longest_burst);
    if (failures == 0 && beats_due.size() == 0) begin
      $display("[burst_memory_slave] OK");
    end else begin
      $display("[burst_memory_slave] ERROR");
    end
    $finish;
  end

endmodule
